### hw/rtl/length_prefixed_frame_receiver_top_macros.svh
// assertion macros for the length-prefixed frame receiver checker
// no dependencies; taken in by `include where assertions are written
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, off while in reset
`define LPFR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpfr assertion failed in %m");

// next-cycle implication, off while in reset
`define LPFR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpfr assertion failed in %m");

// same-cycle implication that also holds across reset
`define LPFR_ASSERT_ALW(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("lpfr assertion failed in %m");

`endif

### hw/rtl/lpfr_pkg.sv
// shared types and constants of the length-prefixed frame receiver
// no dependencies
package lpfr_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd100000;
  localparam logic [15:0] MAX_LEN_RESET = 16'd256;

  typedef enum logic [2:0] {
    EV_ABSORB = 3'd0,
    EV_DATA   = 3'd1,
    EV_LAST   = 3'd2,
    EV_EMPTY  = 3'd3,
    EV_DROP   = 3'd4,
    EV_KEY    = 3'd5,
    EV_STOP   = 3'd6,
    EV_IGN    = 3'd7
  } lpfr_event_t;

  typedef struct packed {
    logic [31:0] frame_timeout_us;
    logic [15:0] max_frame_len;
  } lpfr_cfg_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] arrival_time_us;
  } lpfr_item_t;

  typedef struct packed {
    lpfr_event_t event_res;
    logic [7:0]  payload_byte;
    logic [15:0] frame_len;
    logic [3:0]  key_code;
    logic        timed_out;
  } lpfr_result_t;

endpackage

### hw/rtl/lpfr_ifs.sv
// word channels of the frame receiver: received bytes in, results out
// depends on lpfr_pkg
interface lpfr_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] arrival_time_us;

  modport source (output valid, rx_byte, arrival_time_us, input ready);
  modport sink (input valid, rx_byte, arrival_time_us, output ready);
endinterface

interface lpfr_result_if import lpfr_pkg::*; ();
  logic        valid;
  logic        ready;
  lpfr_event_t event_res;
  logic [7:0]  payload_byte;
  logic [15:0] frame_len;
  logic [3:0]  key_code;
  logic        timed_out;

  modport source (output valid, event_res, payload_byte, frame_len, key_code, timed_out,
                  input ready);
  modport sink (input valid, event_res, payload_byte, frame_len, key_code, timed_out,
                output ready);
endinterface

### hw/rtl/lpfr_cfg_regs.sv
// apb configuration registers: frame timeout and max frame length
// depends on lpfr_pkg
module lpfr_cfg_regs import lpfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output lpfr_cfg_t          cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_timeout_us <= TIMEOUT_RESET;
      cfg.max_frame_len    <= MAX_LEN_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_TIMEOUT: cfg.frame_timeout_us <= pwdata;
        REG_MAX_LEN: cfg.max_frame_len    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TIMEOUT: prdata = cfg.frame_timeout_us;
      REG_MAX_LEN: prdata = {16'd0, cfg.max_frame_len};
      default:     prdata = '0;
    endcase
  end

endmodule

### hw/rtl/lpfr_in_reg.sv
// input register of the frame receiver, refills while the held word leaves
// depends on lpfr_pkg
module lpfr_in_reg import lpfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lpfr_item_t in_item,
  output logic       held_valid,
  output lpfr_item_t held_item,
  input  logic       take
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

### hw/rtl/lpfr_core.sv
// frame state, per-byte decode and result register of the frame receiver
// depends on lpfr_pkg
module lpfr_core import lpfr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  lpfr_cfg_t    cfg,
  input  logic         held_valid,
  input  lpfr_item_t   held_item,
  output logic         take,
  output logic         res_valid,
  input  logic         res_ready,
  output lpfr_result_t res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  localparam logic [7:0] CH_DIG1  = 8'h31;
  localparam logic [7:0] CH_DIG2  = 8'h32;
  localparam logic [7:0] CH_DIG4  = 8'h34;
  localparam logic [7:0] CH_DIG5  = 8'h35;
  localparam logic [7:0] CH_DIG6  = 8'h36;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [1:0] HDR_LAST = 2'd3;

  phase_t       phase, phase_next, phase_eff;
  logic [1:0]   header_count, header_count_next, hc_eff;
  logic [31:0]  length_shift, length_shift_next, shifted;
  logic [15:0]  payload_count, payload_count_next, pc_inc;
  logic [31:0]  last_byte_time, gap;
  logic         tmo;
  logic         is_tele;
  lpfr_event_t  tele_ev;
  logic [3:0]   tele_key;
  lpfr_result_t res_next;
  logic [7:0]   b;

  assign take = held_valid && (!res_valid || res_ready);
  assign b    = held_item.rx_byte;

  // teleop character classes
  always_comb begin
    is_tele  = 1'b1;
    tele_ev  = EV_KEY;
    tele_key = '0;
    if (b >= CH_DIG1 && b <= CH_DIG4) begin
      tele_key = 4'(b - CH_DIG1);
    end else if (b >= CH_DIG6 && b <= CH_DIG9) begin
      tele_key = 4'(b - CH_DIG2);
    end else if (b == CH_O) begin
      tele_key = 4'd8;
    end else if (b == CH_P) begin
      tele_key = 4'd9;
    end else if (b == CH_DIG5 || b == CH_SPACE) begin
      tele_ev = EV_STOP;
    end else if (b == CH_CR || b == CH_LF) begin
      tele_ev = EV_IGN;
    end else begin
      is_tele = 1'b0;
      tele_ev = EV_ABSORB;
    end
  end

  always_comb begin
    gap       = held_item.arrival_time_us - last_byte_time;
    tmo       = (phase == PH_LEN || phase == PH_PAY) && (gap > cfg.frame_timeout_us);
    phase_eff = (tmo || !(phase == PH_LEN || phase == PH_PAY)) ? PH_IDLE : phase;
    hc_eff    = tmo ? 2'd0 : header_count;
    shifted   = {b, length_shift[31:8]};
    pc_inc    = payload_count + 16'd1;

    phase_next         = phase_eff;
    header_count_next  = hc_eff;
    length_shift_next  = length_shift;
    payload_count_next = payload_count;

    res_next           = '0;
    res_next.event_res = EV_ABSORB;
    res_next.timed_out = tmo;

    unique case (phase_eff)
      PH_LEN: begin
        length_shift_next = shifted;
        if (hc_eff < HDR_LAST) begin
          header_count_next = hc_eff + 2'd1;
        end else begin
          header_count_next  = '0;
          payload_count_next = '0;
          if (shifted > {16'd0, cfg.max_frame_len}) begin
            res_next.event_res = EV_DROP;
            phase_next         = PH_IDLE;
          end else if (shifted == '0) begin
            res_next.event_res = EV_EMPTY;
            phase_next         = PH_IDLE;
          end else begin
            phase_next = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        payload_count_next    = pc_inc;
        res_next.payload_byte = b;
        if ({16'd0, pc_inc} < length_shift) begin
          res_next.event_res = EV_DATA;
        end else begin
          res_next.event_res = EV_LAST;
          res_next.frame_len = length_shift[15:0];
          phase_next         = PH_IDLE;
        end
      end
      default: begin
        // idle: teleop chars bypass, anything else opens a header
        if (is_tele) begin
          res_next.event_res = tele_ev;
          res_next.key_code  = tele_key;
        end else begin
          length_shift_next = shifted;
          header_count_next = 2'd1;
          phase_next        = PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      header_count   <= '0;
      length_shift   <= '0;
      payload_count  <= '0;
      last_byte_time <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (take) begin
        phase          <= phase_next;
        header_count   <= header_count_next;
        length_shift   <= length_shift_next;
        payload_count  <= payload_count_next;
        last_byte_time <= held_item.arrival_time_us;
        res_valid      <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

### hw/rtl/length_prefixed_frame_receiver_top.sv
// a byte accepted passes through the input register and then the result register
// throughput: one byte per cycle while result words are taken; every byte gives exactly one result word
// the input register refills while its word moves on, the result register holds a stalled word
// reset (rst, synchronous, active high): idle phase, counters and last time cleared,
// timeout 100000 us and max length 256, both channels empty
module length_prefixed_frame_receiver_top import lpfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  lpfr_byte_if.sink          byte_ch,
  lpfr_result_if.source      result_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  lpfr_cfg_t    cfg;
  lpfr_item_t   in_item, held_item;
  logic         held_valid;
  logic         take;
  lpfr_result_t res;

  // register block: timeout at byte address 0, max length at 4
  lpfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_item.rx_byte         = byte_ch.rx_byte;
  assign in_item.arrival_time_us = byte_ch.arrival_time_us;

  // input register: parts the byte channel from the decode logic
  lpfr_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (byte_ch.valid),
    .in_ready   (byte_ch.ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  // decode: timeout check, teleop bypass, header shift, payload count;
  // the state advances only when the word moves into the result register
  lpfr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take),
    .res_valid  (result_ch.valid),
    .res_ready  (result_ch.ready),
    .res        (res)
  );

  assign result_ch.event_res    = res.event_res;
  assign result_ch.payload_byte = res.payload_byte;
  assign result_ch.frame_len    = res.frame_len;
  assign result_ch.key_code     = res.key_code;
  assign result_ch.timed_out    = res.timed_out;

endmodule

### hw/rtl/lpfr_checker.sv
// port-level checks of the frame receiver, bound to the top level
// depends on lpfr_pkg and length_prefixed_frame_receiver_top_macros.svh
`include "length_prefixed_frame_receiver_top_macros.svh"

module lpfr_checker import lpfr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input lpfr_event_t event_res,
  input logic [7:0]  payload_byte,
  input logic [15:0] frame_len,
  input logic [3:0]  key_code,
  input logic        timed_out
);

  // both sides empty right after reset
  `LPFR_ASSERT_ALW(a_reset_empty, clk, $past(rst), !out_valid && in_ready)

  // a stalled result word holds
  `LPFR_ASSERT_NXT(a_stall_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable({event_res, payload_byte, frame_len, key_code, timed_out}))

  // data and length only travel with payload events
  `LPFR_ASSERT_IMP(a_data_fields, clk, rst, out_valid,
    (payload_byte == 8'd0 || event_res == EV_DATA || event_res == EV_LAST) &&
    (frame_len == 16'd0 || event_res == EV_LAST))

  // key codes only on key events, never above p
  `LPFR_ASSERT_IMP(a_key_field, clk, rst, out_valid,
    (key_code == 4'd0 || event_res == EV_KEY) && key_code <= 4'd9)

endmodule

bind length_prefixed_frame_receiver_top lpfr_checker u_lpfr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (byte_ch.ready),
  .out_valid    (result_ch.valid),
  .out_ready    (result_ch.ready),
  .event_res    (result_ch.event_res),
  .payload_byte (result_ch.payload_byte),
  .frame_len    (result_ch.frame_len),
  .key_code     (result_ch.key_code),
  .timed_out    (result_ch.timed_out)
);
